// File: rtl/core/emt_pkg.sv
// Shared widths, constants and types of the event and GPS time matcher.
package emt_pkg;

  localparam int SEC_W      = 32;
  localparam int RATE_W     = 32;
  localparam int FRAC_W     = 24;
  localparam int TOL_W      = 24;
  localparam int TICK_W     = 24;
  localparam int WHOLE_W    = SEC_W + 1;
  localparam int DELTA_W    = SEC_W + 3;
  localparam int DIVIDEND_W = 56;
  localparam int SUM_W      = 59;
  localparam int OFFSET_W   = 41;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TICK_W-1:0] TICKS_PER_SECOND = 24'd10000000;
  localparam logic [RATE_W-1:0] DEFAULT_CLOCK_RATE_RESET = 32'd200453324;
  localparam logic [TOL_W-1:0]  MATCH_TOLERANCE_RESET = 24'd500000;

  localparam logic signed [SUM_W-1:0] SUM_OFFSET_MAX = 59'sd1099511627775;
  localparam logic signed [SUM_W-1:0] SUM_OFFSET_MIN = -59'sd1099511627776;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_RATE = 1'b0,
    REG_TOLERANCE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/core/emt_div.sv
// Bit-serial restoring divider giving one quotient bit per cycle.
module emt_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [emt_pkg::DIVIDEND_W-1:0]       dividend,
  input  logic [emt_pkg::RATE_W-1:0]           divisor,
  output logic [emt_pkg::DIVIDEND_W-1:0]       quotient,
  output emt_pkg::unit_stat_t                  stat
);

  localparam int DW  = emt_pkg::DIVIDEND_W;
  localparam int RW  = emt_pkg::RATE_W;
  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    work;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    div;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [RW:0]   shifted;
  logic [RW+1:0] diff;
  logic          ge;

  always_comb begin
    shifted = {rem, work[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, div};
    ge      = ~diff[RW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= dividend;
      rem   <= '0;
      div   <= divisor;
      count <= CNT_W'(DW - 1);
    end else if (busy) begin
      work  <= {work[DW-2:0], ge};
      rem   <= ge ? diff[RW-1:0] : shifted[RW-1:0];
      count <= count - 1'b1;
    end
  end

  assign quotient  = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/core/emt_mul.sv
// Serial multiplier by ticks/s, one constant bit per cycle, minus subtrahend.
module emt_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [emt_pkg::DELTA_W-1:0]  multiplicand,
  input  logic [emt_pkg::FRAC_W-1:0]          subtrahend,
  output logic signed [emt_pkg::SUM_W-1:0]    product,
  output emt_pkg::unit_stat_t                 stat
);

  localparam int SW    = emt_pkg::SUM_W;
  localparam int TW    = emt_pkg::TICK_W;
  localparam int CNT_W = $clog2(TW);

  logic signed [SW-1:0]               acc;
  logic signed [emt_pkg::DELTA_W-1:0] mcand;
  logic [emt_pkg::FRAC_W-1:0]         sub;
  logic [CNT_W-1:0]                   count;
  logic                               busy;
  logic                               fix;
  logic                               done;

  logic signed [SW-1:0] addend;

  always_comb begin
    addend = '0;
    if (emt_pkg::TICKS_PER_SECOND[count]) begin
      addend = SW'(mcand);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
      end else if (fix) begin
        busy <= 1'b0;
        fix  <= 1'b0;
        done <= 1'b1;
      end else if (busy && count == '0) begin
        fix <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= multiplicand;
      sub   <= subtrahend;
      count <= CNT_W'(TW - 1);
    end else if (fix) begin
      acc <= acc - $signed({{(SW - emt_pkg::FRAC_W){1'b0}}, sub});
    end else if (busy) begin
      acc   <= (acc <<< 1) + addend;
      count <= count - 1'b1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/core/event_gps_time_matcher_top.sv
// Top level of the event and GPS time matcher: baseline, sequencing and result stage.
//
// One input word carries a trigger event and a GPS timestamp; one output word
// per input word gives the match flag and the saturated signed offset between
// the rebuilt event time and the GPS time, in 100 ns ticks.
// The input side is taken only when the block is idle. A word is accepted,
// then the S_PROD state starts the serial divider on the product of trigger
// clocks and ticks per second, for the sub-second part, one quotient bit at a
// time; the whole-seconds product runs serially beside it. S_SUM adds the
// quotient to that product and S_FIN saturates the sum into the output
// register; only then is a new word accepted.
// The output register holds a finished word while the receiver stalls; the
// next input word is still accepted and worked on, and waits in the final
// stage until the output register is free. Reset clears the baseline, sets
// both configuration registers to their defaults and empties the output
// register. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while no word is in flight, as the block
// itself does not enforce this.
module event_gps_time_matcher_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // event_seconds, pps_count, trigger_clocks, clocks_per_second, gps_seconds,
  // gps_fraction, force_reset, zero fill
  input  logic [emt_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // match, time_offset, zero fill
  output logic [emt_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_we,
  input  logic [emt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [emt_pkg::RATE_W-1:0]         cfg_data
);

  localparam int SW = emt_pkg::SUM_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PROD = 5'b00010,
    S_RUN  = 5'b00100,
    S_SUM  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;

  logic [emt_pkg::RATE_W-1:0]         default_rate;
  logic [emt_pkg::TOL_W-1:0]          tolerance;
  logic [emt_pkg::SEC_W-1:0]          base_sec;
  logic [emt_pkg::SEC_W-1:0]          base_pps;
  logic                               base_valid;
  logic [emt_pkg::SEC_W-1:0]          trig;
  logic [emt_pkg::RATE_W-1:0]         rate;
  logic signed [emt_pkg::DELTA_W-1:0] delta;
  logic [emt_pkg::FRAC_W-1:0]         gps_frac;
  logic                               secs_ok;
  logic signed [SW-1:0]               sum;

  logic [emt_pkg::SEC_W-1:0]   in_ev_sec;
  logic [emt_pkg::SEC_W-1:0]   in_pps;
  logic [emt_pkg::SEC_W-1:0]   in_trig;
  logic [emt_pkg::RATE_W-1:0]  in_cps;
  logic [emt_pkg::SEC_W-1:0]   in_gps_sec;
  logic [emt_pkg::FRAC_W-1:0]  in_gps_frac;
  logic                        in_force;

  logic                               take;
  logic [emt_pkg::WHOLE_W-1:0]        whole_next;
  logic signed [emt_pkg::DELTA_W-1:0] delta_next;
  logic [emt_pkg::SEC_W:0]            sec_diff;
  logic [emt_pkg::RATE_W-1:0]         rate_next;
  logic                               accept;

  logic [emt_pkg::DIVIDEND_W-1:0] dividend;
  logic [emt_pkg::DIVIDEND_W-1:0] quotient;
  logic signed [SW-1:0]           product;
  emt_pkg::unit_stat_t            div_stat;
  emt_pkg::unit_stat_t            mul_stat;
  logic                           unit_start;

  logic signed [SW-1:0]               tol_s;
  logic                               in_window;
  logic [emt_pkg::OFFSET_W-1:0]       offset;
  logic                               out_free;

  assign in_ev_sec   = s_tdata[31:0];
  assign in_pps      = s_tdata[63:32];
  assign in_trig     = s_tdata[95:64];
  assign in_cps      = s_tdata[127:96];
  assign in_gps_sec  = s_tdata[159:128];
  assign in_gps_frac = s_tdata[183:160];
  assign in_force    = s_tdata[184];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    take = ~base_valid || in_force || (in_pps < base_pps);
    if (take) begin
      whole_next = {1'b0, in_ev_sec};
    end else begin
      whole_next = {1'b0, base_sec} + {1'b0, in_pps - base_pps};
    end
    delta_next = $signed({2'b00, whole_next}) - $signed({3'b000, in_gps_sec});
    sec_diff   = {1'b0, in_ev_sec} - {1'b0, in_gps_sec};
    if (in_cps != '0) begin
      rate_next = in_cps;
    end else if (default_rate != '0) begin
      rate_next = default_rate;
    end else begin
      rate_next = emt_pkg::RATE_W'(1);
    end
  end

  assign unit_start = (state == S_PROD);
  assign dividend   = emt_pkg::DIVIDEND_W'(trig) *
                      emt_pkg::DIVIDEND_W'(emt_pkg::TICKS_PER_SECOND);

  emt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (unit_start),
    .dividend (dividend),
    .divisor  (rate),
    .quotient (quotient),
    .stat     (div_stat)
  );

  emt_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (unit_start),
    .multiplicand (delta),
    .subtrahend   (gps_frac),
    .product      (product),
    .stat         (mul_stat)
  );

  always_comb begin
    tol_s = $signed({{(SW - emt_pkg::TOL_W){1'b0}}, tolerance});
    if (sum[SW-1]) begin
      in_window = (sum + tol_s) > $signed(SW'(0));
    end else begin
      in_window = sum < tol_s;
    end
    if (sum > emt_pkg::SUM_OFFSET_MAX) begin
      offset = emt_pkg::SUM_OFFSET_MAX[emt_pkg::OFFSET_W-1:0];
    end else if (sum < emt_pkg::SUM_OFFSET_MIN) begin
      offset = emt_pkg::SUM_OFFSET_MIN[emt_pkg::OFFSET_W-1:0];
    end else begin
      offset = sum[emt_pkg::OFFSET_W-1:0];
    end
    out_free = ~m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_rate <= emt_pkg::DEFAULT_CLOCK_RATE_RESET;
      tolerance    <= emt_pkg::MATCH_TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (emt_pkg::cfg_reg_t'(cfg_index))
        emt_pkg::REG_DEFAULT_RATE: begin
          default_rate <= cfg_data;
        end
        emt_pkg::REG_TOLERANCE: begin
          tolerance <= cfg_data[emt_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_valid <= 1'b0;
      base_sec   <= '0;
      base_pps   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (take) begin
              base_sec   <= in_ev_sec;
              base_pps   <= in_pps;
              base_valid <= 1'b1;
            end
            state <= S_PROD;
          end
        end
        S_PROD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (div_stat.done && !mul_stat.busy) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trig     <= in_trig;
      rate     <= rate_next;
      delta    <= delta_next;
      gps_frac <= in_gps_frac;
      secs_ok  <= (sec_diff == '0) || (sec_diff == (emt_pkg::SEC_W + 1)'(1)) ||
                  (sec_diff == '1);
    end
    if (state == S_SUM) begin
      sum <= product + $signed({3'b000, quotient});
    end
    if (state == S_FIN && out_free) begin
      m_tdata <= {{(emt_pkg::OUT_DATA_W - emt_pkg::OFFSET_W - 1){1'b0}},
                  offset, secs_ok && in_window};
    end
  end

endmodule

// File: rtl/core/emt_chk.sv
// Port checker of the event and GPS time matcher, bound to the top level.
module emt_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [emt_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // Only one word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a word is in flight");

  // A result never appears while the word just taken is in S_PROD or has just entered S_RUN.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("result appeared too early");

  // Reset empties the output and leaves the block ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind event_gps_time_matcher_top emt_chk u_emt_chk (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the event and GPS time matcher top level.
module tb_top;

  localparam logic [63:0] TICKS64 = 64'd10000000;
  localparam logic [63:0] OFF_LIM = 64'd1 << 40;
  localparam int HOLD_AT = 120;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 200000;

  typedef struct {
    logic [31:0] ev_sec;
    logic [31:0] pps;
    logic [31:0] trig;
    logic [31:0] cps;
    logic [31:0] gps_sec;
    logic [23:0] gps_frac;
    logic        rebase;
  } trig_event_t;

  typedef struct {
    logic               hit;
    logic signed [40:0] offset;
  } match_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [emt_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [emt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [emt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [emt_pkg::RATE_W-1:0] cfg_data = '0;

  trig_event_t pending_events[$];
  match_res_t expected_results[$];
  trig_event_t tx_cur;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int results_seen = 0;
  int err_cnt = 0;
  logic idle_on = 1'b1;

  logic [31:0] cfg_rate = emt_pkg::DEFAULT_CLOCK_RATE_RESET;
  logic [23:0] cfg_tol = emt_pkg::MATCH_TOLERANCE_RESET;
  logic [31:0] bl_sec = '0;
  logic [31:0] bl_pps = '0;
  logic bl_valid = 1'b0;

  logic [31:0] sess_sec = '0;
  logic [31:0] sess_pps = '0;
  int sess_k = 0;
  int sess_left = 0;

  event_gps_time_matcher_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [emt_pkg::IN_DATA_W-1:0] pack_event(input trig_event_t e);
    return {7'd0, e.rebase, e.gps_frac, e.gps_sec, e.cps, e.trig, e.pps, e.ev_sec};
  endfunction

  function automatic void predict_match(input trig_event_t e);
    logic [63:0] rate, whole, frac, ev_t, gps_t, mag, lim, neg_m;
    logic [31:0] pps_step, sec_gap;
    logic neg;
    match_res_t r;
    if (!bl_valid || e.rebase || e.pps < bl_pps) begin
      bl_sec = e.ev_sec;
      bl_pps = e.pps;
      bl_valid = 1'b1;
    end
    rate = (e.cps != 32'd0) ? {32'd0, e.cps} : {32'd0, cfg_rate};
    if (rate == 64'd0) rate = 64'd1;
    pps_step = e.pps - bl_pps;
    whole = {32'd0, bl_sec} + {32'd0, pps_step};
    frac = ({32'd0, e.trig} * TICKS64) / rate;
    ev_t = whole * TICKS64 + frac;
    gps_t = {32'd0, e.gps_sec} * TICKS64 + {40'd0, e.gps_frac};
    neg = ev_t < gps_t;
    mag = neg ? gps_t - ev_t : ev_t - gps_t;
    sec_gap = (e.ev_sec >= e.gps_sec) ? e.ev_sec - e.gps_sec : e.gps_sec - e.ev_sec;
    r.hit = (sec_gap <= 32'd1) && (mag < {40'd0, cfg_tol});
    if (neg) begin
      lim = (mag > OFF_LIM) ? OFF_LIM : mag;
      neg_m = ~lim + 64'd1;
      r.offset = neg_m[40:0];
    end else begin
      lim = (mag > OFF_LIM - 64'd1) ? OFF_LIM - 64'd1 : mag;
      r.offset = lim[40:0];
    end
    expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin : send_proc
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_match(tx_cur);
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_events.size() != 0) begin
          if (idle_on && $urandom_range(3) == 0) begin
            tx_gap <= $urandom_range(3);
          end else begin
            tx_cur = pending_events.pop_front();
            s_tdata <= pack_event(tx_cur);
            offer = 1'b1;
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  always @(posedge clk) begin : hold_proc
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : recv_proc
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      rx_gap <= $urandom_range(3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_proc
    match_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tdata[0];
      got.offset = m_tdata[41:1];
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        if (err_cnt < 10)
          $display("word %0d arrived with nothing expected: hit %0b offset %0d",
                   results_seen, got.hit, got.offset);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit || got.offset !== want.offset) begin
          if (err_cnt < 10)
            $display("word %0d: expected hit %0b offset %0d, got hit %0b offset %0d",
                     results_seen, want.hit, want.offset, got.hit, got.offset);
          err_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input emt_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == emt_pkg::REG_DEFAULT_RATE) cfg_rate = val;
    else cfg_tol = val[23:0];
    @(negedge clk);
  endtask

  task automatic add_event(input logic [31:0] ev_sec, input logic [31:0] pps,
                           input logic [31:0] trig, input logic [31:0] cps,
                           input logic [31:0] gps_sec, input logic [23:0] gps_frac,
                           input logic rebase);
    trig_event_t e;
    e.ev_sec = ev_sec;
    e.pps = pps;
    e.trig = trig;
    e.cps = cps;
    e.gps_sec = gps_sec;
    e.gps_frac = gps_frac;
    e.rebase = rebase;
    pending_events.push_back(e);
  endtask

  task automatic add_random(input int n);
    trig_event_t e;
    logic [63:0] rate, evt_ticks;
    longint jit, gt;
    int unsigned pick, span;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(19);
      if (pick < 2) begin
        e.ev_sec = $urandom;
        e.pps = $urandom;
        e.trig = $urandom;
        e.cps = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        e.gps_sec = $urandom;
        e.gps_frac = 24'($urandom);
        e.rebase = 1'($urandom_range(1));
        sess_left = 0;
      end else if (pick == 2 && sess_left != 0) begin
        e.pps = sess_pps - $urandom_range(5, 1);
        e.ev_sec = sess_sec + $urandom_range(3);
        e.trig = $urandom;
        e.cps = $urandom_range(210000000, 190000000);
        e.gps_sec = e.ev_sec;
        e.gps_frac = 24'($urandom_range(9999999));
        e.rebase = 1'b0;
        sess_left = 0;
      end else begin
        if (sess_left == 0) begin
          sess_sec = $urandom_range(32'hFFF00000);
          sess_pps = $urandom_range(32'hFFFF0000);
          sess_k = 0;
          sess_left = $urandom_range(12, 3);
          e.rebase = 1'b1;
        end else begin
          sess_k += $urandom_range(3);
          e.rebase = 1'b0;
        end
        sess_left--;
        e.pps = sess_pps + sess_k;
        e.ev_sec = sess_sec + sess_k;
        pick = $urandom_range(7);
        if (pick < 2) e.cps = 32'd0;
        else if (pick == 2) e.cps = $urandom;
        else e.cps = $urandom_range(210000000, 190000000);
        rate = (e.cps != 32'd0) ? {32'd0, e.cps} : {32'd0, cfg_rate};
        if (rate == 64'd0) rate = 64'd1;
        if ($urandom_range(9) == 0) e.trig = $urandom;
        else e.trig = (rate > 64'd1) ? $urandom_range(rate[31:0] - 32'd1) : 32'd0;
        evt_ticks = ({32'd0, sess_sec} + 64'(sess_k)) * TICKS64
                    + ({32'd0, e.trig} * TICKS64) / rate;
        if ($urandom_range(4) == 0) begin
          jit = longint'(cfg_tol) - longint'($urandom_range(1));
          if ($urandom_range(1) == 1) jit = -jit;
        end else begin
          span = 2 * cfg_tol + 2;
          jit = longint'($urandom_range(span)) - longint'(cfg_tol) - 1;
        end
        gt = longint'(evt_ticks) - jit;
        if (gt < 0) gt = 0;
        e.gps_sec = 32'(gt / longint'(TICKS64));
        e.gps_frac = 24'(gt % longint'(TICKS64));
        if (!e.rebase && $urandom_range(7) == 0)
          e.ev_sec = e.ev_sec + $urandom_range(4) - 32'd2;
        if ($urandom_range(9) == 0 && e.gps_sec != 0 && e.gps_frac < 24'd6777216) begin
          e.gps_sec = e.gps_sec - 32'd1;
          e.gps_frac = e.gps_frac + 24'd10000000;
        end
      end
      pending_events.push_back(e);
    end
  endtask

  task automatic drain_results();
    int n = 0;
    while (n < DRAIN_LIMIT &&
           (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stim
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_event(32'd1000, 32'd50, 32'd100226662, 32'd200453324, 32'd1000, 24'd5000000, 1'b0);
    add_event(32'd1002, 32'd52, 32'd0, 32'd0, 32'd1002, 24'd499999, 1'b0);
    add_event(32'd1002, 32'd52, 32'd0, 32'd0, 32'd1002, 24'd500000, 1'b0);
    add_event(32'd1003, 32'd53, 32'd0, 32'd0, 32'd1002, 24'd9500001, 1'b0);
    add_event(32'd1007, 32'd55, 32'd0, 32'd0, 32'd1005, 24'd0, 1'b0);
    add_event(32'd2000, 32'd10, 32'd0, 32'd0, 32'd2000, 24'd0, 1'b0);
    add_event(32'd3000, 32'd20, 32'd0, 32'd0, 32'd3000, 24'd123, 1'b1);
    add_event(32'd3000, 32'd21, 32'd0, 32'd0, 32'd3000, 24'hFFFFFF, 1'b0);
    add_event(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 32'd0, 24'd0, 1'b1);
    add_event(32'd0, 32'd0, 32'd0, 32'd5, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
    add_event(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              24'd9999999, 1'b1);
    add_event(32'd12345, 32'd0, 32'h000FFFFF, 32'd1000, 32'd12345, 24'd0, 1'b0);
    add_event(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 24'd0, 1'b1);
    add_event(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 24'd0, 1'b0);
    add_event(32'd5, 32'd3, 32'd0, 32'd0, 32'd4, 24'd0, 1'b0);
    add_random(60);
    drain_results();

    write_reg(emt_pkg::REG_DEFAULT_RATE, 32'd0);
    write_reg(emt_pkg::REG_TOLERANCE, 32'h00FFFFFF);
    add_event(32'd500, 32'd7, 32'd1, 32'd0, 32'd499, 24'd3222786, 1'b1);
    add_event(32'd500, 32'd7, 32'd1, 32'd0, 32'd499, 24'd3222785, 1'b0);
    add_random(60);
    drain_results();

    write_reg(emt_pkg::REG_DEFAULT_RATE, 32'hFFFFFFFF);
    write_reg(emt_pkg::REG_TOLERANCE, 32'd0);
    add_event(32'd7, 32'd1, 32'd0, 32'd0, 32'd7, 24'd0, 1'b1);
    add_event(32'd7, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd8, 24'd0, 1'b0);
    add_random(60);
    drain_results();

    write_reg(emt_pkg::REG_DEFAULT_RATE, 32'd1);
    write_reg(emt_pkg::REG_TOLERANCE, 32'd10000000);
    add_random(100);
    drain_results();

    for (int p = 0; p < 2; p++) begin
      write_reg(emt_pkg::REG_DEFAULT_RATE, $urandom_range(32'hEE6B2800, 32'd1000000));
      write_reg(emt_pkg::REG_TOLERANCE, $urandom_range(10000000));
      add_random(100);
      drain_results();
    end

    idle_on = 1'b0;
    write_reg(emt_pkg::REG_DEFAULT_RATE, emt_pkg::DEFAULT_CLOCK_RATE_RESET);
    write_reg(emt_pkg::REG_TOLERANCE, $urandom_range(10000000));
    add_random(100);
    drain_results();

    if (expected_results.size() != 0) begin
      $display("%0d expected words never arrived", expected_results.size());
      err_cnt += expected_results.size();
    end
    if (err_cnt == 0) begin
      $display("[event_gps_time_matcher_top] OK");
    end else begin
      $display("[event_gps_time_matcher_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[event_gps_time_matcher_top] ERROR");
    $finish;
  end

endmodule
